/* design/gmdfs_pkg.sv */
// gmdfs_pkg: shared types and constants for the grid maze path finder
// used by gmdfs_ctrl, gmdfs_dp and the top level

package gmdfs_pkg;

    localparam int MaxRows = 64;
    localparam int MaxCols = 64;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_SOLVE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CODE_OPEN  = 2'd0,
        CODE_WALL  = 2'd1,
        CODE_START = 2'd2,
        CODE_EXIT  = 2'd3
    } code_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOPATH = 2'd1,
        ST_BADCNT = 2'd2,
        ST_RANGE  = 2'd3
    } status_t;

    localparam logic [0:0] REG_ROWS = 1'b0;
    localparam logic [0:0] REG_COLS = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic scan_start;   // clear scan, clear and count registers and the depth
        logic scan_step;    // read next cell of active area
        logic scan_last;    // final scan data arriving
        logic init_push;    // push start cell
        logic top_read;     // load top position and direction from the stack
        logic explore;      // evaluate neighbor of top
        logic check;        // push the free neighbor, marking it unless it is the exit
        logic pop;          // back out of top
        logic clear_step;   // clear one mark
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic scan_done;
        logic count_ok;
        logic dir_done;     // top exhausted all four directions
        logic nb_valid;     // neighbor inside bounds
        logic nb_exit;
        logic nb_free;      // not a wall and unmarked
        logic stack_empty;
        logic stack_full;
        logic clear_done;
    } stat_t;

endpackage

/* design/grid_maze_dfs_path_finder.sv */
// grid_maze_dfs_path_finder: top level of the backtracking maze solver
// depends on gmdfs_pkg, gmdfs_ctrl and gmdfs_dp

// Write items and unknown kinds raise their result item the cycle after they
// are taken, and the next item is taken the cycle after the result leaves;
// read items first pass through the registered stack read. A solve item
// clears every visit mark of the store, scans the active area one cell a
// cycle to count start and exit cells, then walks the search: each neighbor
// is probed, and one inside the active area also goes through the memory
// read and the check, each back-out pops the stack, and each new top of
// stack is reloaded from the stack memories. Its time is data dependent.

module grid_maze_dfs_path_finder
    import gmdfs_pkg::*;
#(
    parameter int MAX_ROWS_P = MaxRows,
    parameter int MAX_COLS_P = MaxCols
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // kind, cell_row, cell_col, cell_code, step_index, zero fill
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status, path_length, path_row, path_col, zero fill
    output logic [31:0] m_tdata
);

    localparam int Cells = MAX_ROWS_P * MAX_COLS_P;

    logic [6:0] row_count_reg, col_count_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= 7'd64;
            col_count_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_ROWS) row_count_reg <= cfg_data;
            if (cfg_index == REG_COLS) col_count_reg <= cfg_data;
        end
    end

    logic [1:0]  kind;
    logic [5:0]  cell_row, cell_col;
    logic [1:0]  cell_code;
    logic [11:0] step_index;
    assign kind       = s_tdata[1:0];
    assign cell_row   = s_tdata[7:2];
    assign cell_col   = s_tdata[13:8];
    assign cell_code  = s_tdata[15:14];
    assign step_index = s_tdata[27:16];

    // busy covers the solve walk and a pending read
    logic busy_reg, rd_pend_reg, solving_reg;
    logic accept;
    assign s_tready = !busy_reg && !m_tvalid;
    assign accept   = s_tvalid && s_tready;

    cmd_t  cmd;
    stat_t st;
    logic  done, fin_found, fin_bad;
    logic  rd_en;
    logic [5:0] rd_row, rd_col;

    gmdfs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .go(accept && kind == KIND_SOLVE),
        .st(st), .cmd(cmd), .done(done),
        .fin_found(fin_found), .fin_bad(fin_bad)
    );

    // path length at a find is depth+1, captured when the solve finishes
    logic [1:0]  outcome_reg;
    logic [12:0] found_len_reg;
    logic [12:0] depth_cnt_reg;

    logic rd_ok;
    assign rd_ok = outcome_reg == ST_OK && 32'(step_index) < 32'(found_len_reg)
                   && 32'(step_index) < Cells;
    assign rd_en = accept && kind == KIND_READ && rd_ok;

    gmdfs_dp #(.MAX_ROWS_P(MAX_ROWS_P), .MAX_COLS_P(MAX_COLS_P)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
        .row_count(row_count_reg), .col_count(col_count_reg),
        .wr_en(accept && kind == KIND_WRITE),
        .wr_row(cell_row), .wr_col(cell_col), .wr_code(cell_code),
        .rd_en(rd_en), .rd_index(step_index),
        .rd_row(rd_row), .rd_col(rd_col)
    );

    logic [1:0]  o_status_reg;
    logic [12:0] o_len_reg;
    logic [5:0]  o_row_reg, o_col_reg;
    logic        o_use_rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rd_pend_reg   <= 1'b0;
            solving_reg   <= 1'b0;
            m_tvalid      <= 1'b0;
            outcome_reg   <= ST_NOPATH;
            found_len_reg <= '0;
            depth_cnt_reg <= '0;
            o_status_reg  <= '0;
            o_len_reg     <= '0;
            o_row_reg     <= '0;
            o_col_reg     <= '0;
            o_use_rd_reg  <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                m_tvalid <= 1'b0;
            // track stack depth alongside the datapath
            if (cmd.init_push) depth_cnt_reg <= 13'd1;
            if (cmd.pop)       depth_cnt_reg <= depth_cnt_reg - 13'd1;
            if (cmd.check)     depth_cnt_reg <= depth_cnt_reg + 13'd1;
            if (accept)
            begin
                o_row_reg    <= '0;
                o_col_reg    <= '0;
                o_use_rd_reg <= 1'b0;
                o_status_reg <= ST_OK;
                o_len_reg    <= '0;
                case (kind)
                    KIND_SOLVE:
                    begin
                        busy_reg    <= 1'b1;
                        solving_reg <= 1'b1;
                    end
                    KIND_READ:
                    begin
                        busy_reg    <= 1'b1;
                        rd_pend_reg <= 1'b1;
                        if (outcome_reg != ST_OK)
                            o_status_reg <= outcome_reg;
                        else if (!rd_ok)
                        begin
                            o_status_reg <= ST_RANGE;
                            o_len_reg    <= found_len_reg;
                        end
                        else
                        begin
                            o_len_reg    <= found_len_reg;
                            o_use_rd_reg <= 1'b1;
                        end
                    end
                    default:
                        m_tvalid <= 1'b1;
                endcase
            end
            if (rd_pend_reg)
            begin
                rd_pend_reg <= 1'b0;
                busy_reg    <= 1'b0;
                m_tvalid    <= 1'b1;
            end
            if (solving_reg && done)
            begin
                solving_reg <= 1'b0;
                busy_reg    <= 1'b0;
                m_tvalid    <= 1'b1;
                if (fin_bad)
                begin
                    outcome_reg   <= ST_BADCNT;
                    found_len_reg <= '0;
                    o_status_reg  <= ST_BADCNT;
                    o_len_reg     <= '0;
                end
                else if (fin_found)
                begin
                    outcome_reg   <= ST_OK;
                    found_len_reg <= depth_cnt_reg;
                    o_status_reg  <= ST_OK;
                    o_len_reg     <= depth_cnt_reg;
                end
                else
                begin
                    outcome_reg   <= ST_NOPATH;
                    found_len_reg <= '0;
                    o_status_reg  <= ST_NOPATH;
                    o_len_reg     <= '0;
                end
            end
        end
    end

    assign m_tdata = {5'd0,
                      o_use_rd_reg ? rd_col : 6'd0,
                      o_use_rd_reg ? rd_row : 6'd0,
                      o_len_reg, o_status_reg};

    // the walk never runs while an item waits at the output
    a_solve_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        solving_reg |-> !m_tvalid)
        else $error("result shown during solve");

    // a finished solve raises the result next cycle
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (solving_reg && done) |=> m_tvalid)
        else $error("solve result lost");

    // no input taken while busy
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !s_tready)
        else $error("accepted while busy");

endmodule

/* design/gmdfs_ctrl.sv */
// gmdfs_ctrl: sequencer for the solve walk
// depends on gmdfs_pkg

module gmdfs_ctrl
    import gmdfs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  go,
    input  stat_t st,
    output cmd_t  cmd,
    output logic  done,
    output logic  fin_found,
    output logic  fin_bad
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CLEAR = 11'b00000000010,
        S_SCAN  = 11'b00000000100,
        S_SWAIT = 11'b00000001000,
        S_INIT  = 11'b00000010000,
        S_TOP   = 11'b00000100000,
        S_LOAD  = 11'b00001000000,
        S_EXPL  = 11'b00010000000,
        S_WAIT  = 11'b00100000000,
        S_CHECK = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic found_reg, found_next, bad_reg, bad_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            found_reg <= 1'b0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
            bad_reg   <= bad_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        found_next = found_reg;
        bad_next   = bad_reg;
        cmd        = '0;
        done       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    cmd.scan_start = 1'b1;
                    found_next = 1'b0;
                    bad_next   = 1'b0;
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (st.clear_done)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (st.scan_done)
                    state_next = S_SWAIT;
            end
            S_SWAIT:
            begin
                cmd.scan_last = 1'b1;
                state_next = S_INIT;
            end
            S_INIT:
            begin
                if (!st.count_ok)
                begin
                    bad_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.init_push = 1'b1;
                    state_next = S_TOP;
                end
            end
            S_TOP:
            begin
                if (st.stack_empty)
                    state_next = S_DONE;
                else
                begin
                    cmd.top_read = 1'b1;
                    state_next = S_LOAD;
                end
            end
            // stack read data lands in the top registers
            S_LOAD:
                state_next = S_EXPL;
            S_EXPL:
            begin
                if (st.dir_done)
                begin
                    cmd.pop = 1'b1;
                    state_next = S_TOP;
                end
                else
                begin
                    cmd.explore = 1'b1;
                    state_next = st.nb_valid ? S_WAIT : S_EXPL;
                end
            end
            S_WAIT:
                state_next = S_CHECK;
            S_CHECK:
            begin
                if (!st.nb_free || st.stack_full)
                    state_next = S_EXPL;
                else
                begin
                    cmd.check = 1'b1;
                    if (st.nb_exit)
                    begin
                        found_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_TOP;
                end
            end
            S_DONE:
            begin
                done = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign fin_found = found_reg;
    assign fin_bad   = bad_reg;

endmodule

/* design/gmdfs_dp.sv */
// gmdfs_dp: grid store, visit marks, search stack and walk registers
// depends on gmdfs_pkg

module gmdfs_dp
    import gmdfs_pkg::*;
#(
    parameter int MAX_ROWS_P = MaxRows,
    parameter int MAX_COLS_P = MaxCols
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       st,
    input  logic [6:0]  row_count,
    input  logic [6:0]  col_count,
    input  logic        wr_en,
    input  logic [5:0]  wr_row,
    input  logic [5:0]  wr_col,
    input  logic [1:0]  wr_code,
    input  logic        rd_en,
    input  logic [11:0] rd_index,
    output logic [5:0]  rd_row,
    output logic [5:0]  rd_col
);

    localparam int RW = (MAX_ROWS_P > 1) ? $clog2(MAX_ROWS_P) : 1;
    localparam int CW = (MAX_COLS_P > 1) ? $clog2(MAX_COLS_P) : 1;
    localparam int AW = RW + CW;
    localparam int Cells = MAX_ROWS_P * MAX_COLS_P;
    localparam int DW = $clog2(Cells + 1);
    localparam int RCW = $clog2(MAX_ROWS_P + 1);
    localparam int CCW = $clog2(MAX_COLS_P + 1);

    logic [1:0]    grid_mem [Cells];
    logic          mark_mem [Cells];
    logic [AW-1:0] pos_mem  [Cells];
    logic [2:0]    dir_mem  [Cells];

    // clamped active size
    logic [RCW-1:0] rows;
    logic [CCW-1:0] cols;
    always_comb
    begin
        if (row_count == 7'd0) rows = RCW'(1);
        else if (32'(row_count) > MAX_ROWS_P) rows = RCW'(MAX_ROWS_P);
        else rows = RCW'(row_count);
        if (col_count == 7'd0) cols = CCW'(1);
        else if (32'(col_count) > MAX_COLS_P) cols = CCW'(MAX_COLS_P);
        else cols = CCW'(col_count);
    end

    // scan / clear counters
    logic [RW-1:0] sr_reg;
    logic [CW-1:0] sc_reg;
    logic [AW:0]   clr_reg;
    logic          sv_reg;
    logic [AW-1:0] sp_reg;
    logic [1:0]    starts_reg, exits_reg;
    logic [AW-1:0] start_reg;
    logic [1:0]    gq_reg;

    // walk registers
    logic [DW-1:0] depth_reg;
    logic [AW-1:0] top_pos_reg;
    logic [2:0]    top_dir_reg;
    logic [AW-1:0] nb_reg;
    logic [1:0]    nb_code_reg;
    logic          nb_mark_reg;

    logic          scan_lastc;
    assign scan_lastc = (32'(sr_reg) == 32'(rows) - 1) && (32'(sc_reg) == 32'(cols) - 1);

    // neighbor compute from top and current direction
    logic          nb_ok;
    logic [AW-1:0] nb_pos;
    logic [RW-1:0] tr;
    logic [CW-1:0] tc;
    always_comb
    begin
        tr = top_pos_reg[AW-1:CW];
        tc = top_pos_reg[CW-1:0];
        nb_ok  = 1'b0;
        nb_pos = top_pos_reg;
        case (top_dir_reg[1:0])
            2'd0:
            begin
                nb_ok  = tr != '0;
                nb_pos = {tr - RW'(1), tc};
            end
            2'd1:
            begin
                nb_ok  = 32'(tr) + 1 < 32'(rows);
                nb_pos = {tr + RW'(1), tc};
            end
            2'd2:
            begin
                nb_ok  = tc != '0;
                nb_pos = {tr, tc - CW'(1)};
            end
            default:
            begin
                nb_ok  = 32'(tc) + 1 < 32'(cols);
                nb_pos = {tr, tc + CW'(1)};
            end
        endcase
    end

    // grid memory: one write port, one registered read
    logic [AW-1:0] g_addr;
    always_comb
    begin
        if (cmd.scan_step) g_addr = {sr_reg, sc_reg};
        else g_addr = nb_pos;
    end
    always_ff @(posedge clk)
    begin
        if (wr_en && 32'(wr_row) < MAX_ROWS_P && 32'(wr_col) < MAX_COLS_P)
            grid_mem[{RW'(wr_row), CW'(wr_col)}] <= wr_code;
        gq_reg <= grid_mem[g_addr];
    end

    // mark memory
    logic          m_we, m_wd;
    logic [AW-1:0] m_wa;
    always_comb
    begin
        m_we = 1'b0;
        m_wd = 1'b0;
        m_wa = top_pos_reg;
        if (cmd.clear_step)
        begin
            m_we = !clr_reg[AW];
            m_wa = clr_reg[AW-1:0];
        end
        else if (cmd.init_push)
        begin
            m_we = 1'b1;
            m_wd = 1'b1;
            m_wa = start_reg;
        end
        else if (cmd.check && nb_code_reg != CODE_EXIT)
        begin
            m_we = 1'b1;
            m_wd = 1'b1;
            m_wa = nb_reg;
        end
        else if (cmd.pop)
            m_we = 1'b1;
    end
    // mark of the held neighbor, valid in the check cycle
    always_ff @(posedge clk)
    begin
        if (m_we)
            mark_mem[m_wa] <= m_wd;
        nb_mark_reg <= mark_mem[nb_reg];
    end

    // stack memories
    logic          s_we;
    logic [DW-1:0] s_wa_full;
    logic [AW-1:0] s_wp;
    logic [2:0]    s_wd;
    logic [DW-1:0] top_idx;
    assign top_idx = depth_reg - DW'(1);
    always_comb
    begin
        s_we = 1'b0;
        s_wa_full = depth_reg;
        s_wp = nb_reg;
        s_wd = 3'd0;
        if (cmd.init_push)
        begin
            s_we = 1'b1;
            s_wa_full = '0;
            s_wp = start_reg;
        end
        else if (cmd.check)
            s_we = 1'b1;
    end
    always_ff @(posedge clk)
    begin
        if (s_we)
            pos_mem[s_wa_full[AW-1:0]] <= s_wp;
        if (s_we)
            dir_mem[s_wa_full[AW-1:0]] <= s_wd;
        else if (cmd.explore)
            dir_mem[top_idx[AW-1:0]] <= top_dir_reg + 3'd1;
        if (rd_en)
        begin
            rd_row <= 6'(pos_mem[rd_index[AW-1:0]][AW-1:CW]);
            rd_col <= 6'(pos_mem[rd_index[AW-1:0]][CW-1:0]);
        end
    end

    // top readout: stack words are registered and loaded into the top registers in the cycle after top_read
    logic          top_ld_reg;
    logic [AW-1:0] tp_q;
    logic [2:0]    td_q;
    always_ff @(posedge clk)
    begin
        tp_q <= pos_mem[top_idx[AW-1:0]];
        td_q <= dir_mem[top_idx[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sr_reg <= '0;
            sc_reg <= '0;
            clr_reg <= '0;
            sv_reg <= 1'b0;
            sp_reg <= '0;
            starts_reg <= '0;
            exits_reg <= '0;
            start_reg <= '0;
            depth_reg <= '0;
            top_ld_reg <= 1'b0;
            top_dir_reg <= '0;
            top_pos_reg <= '0;
            nb_reg <= '0;
            nb_code_reg <= '0;
        end
        else
        begin
            sv_reg <= cmd.scan_step;
            sp_reg <= {sr_reg, sc_reg};
            top_ld_reg <= cmd.top_read;
            if (cmd.scan_start)
            begin
                sr_reg <= '0;
                sc_reg <= '0;
                clr_reg <= '0;
                starts_reg <= '0;
                exits_reg <= '0;
                depth_reg <= '0;
            end
            if (cmd.clear_step && !clr_reg[AW])
                clr_reg <= clr_reg + (AW+1)'(1);
            if (cmd.scan_step && !scan_lastc)
            begin
                if (32'(sc_reg) == 32'(cols) - 1)
                begin
                    sc_reg <= '0;
                    sr_reg <= sr_reg + RW'(1);
                end
                else
                    sc_reg <= sc_reg + CW'(1);
            end
            if (sv_reg)
            begin
                if (gq_reg == CODE_START)
                begin
                    if (starts_reg != 2'd2) starts_reg <= starts_reg + 2'd1;
                    start_reg <= sp_reg;
                end
                else if (gq_reg == CODE_EXIT && exits_reg != 2'd2)
                    exits_reg <= exits_reg + 2'd1;
            end
            if (cmd.init_push)
                depth_reg <= DW'(1);
            if (top_ld_reg)
            begin
                top_pos_reg <= tp_q;
                top_dir_reg <= td_q;
            end
            if (cmd.explore)
            begin
                top_dir_reg <= top_dir_reg + 3'd1;
                nb_reg <= nb_pos;
            end
            if (cmd.pop)
                depth_reg <= depth_reg - DW'(1);
            if (cmd.check)
                depth_reg <= depth_reg + DW'(1);
            nb_code_reg <= gq_reg;
        end
    end

    assign st.scan_done   = cmd.scan_step && scan_lastc;
    assign st.count_ok    = starts_reg == 2'd1 && exits_reg == 2'd1;
    assign st.dir_done    = top_dir_reg[2];
    assign st.nb_valid    = nb_ok;
    assign st.nb_exit     = nb_code_reg == CODE_EXIT;
    assign st.nb_free     = nb_code_reg != CODE_WALL && !nb_mark_reg;
    assign st.stack_empty = depth_reg == '0;
    assign st.stack_full  = 32'(depth_reg) >= Cells;
    assign st.clear_done  = clr_reg[AW];

    // depth is not exported; the top level tracks its own copy for the path length
endmodule

/* tb/testbench.sv */
// testbench: self-checking bench for grid_maze_dfs_path_finder
// depends on gmdfs_pkg and the top level; a local path search predicts the result items the plan table does not give

`timescale 1ns / 1ps

module testbench;
    import gmdfs_pkg::*;

    localparam int GridCols = 64;
    localparam int GridCells = 64 * 64;
    localparam int CycleLimit = 3000000;
    localparam int IdlePct = 26;

    // one predicted result item
    typedef struct {
        status_t     status;
        logic [12:0] length;
        logic [5:0]  row;
        logic [5:0]  col;
    } path_result_t;

    // one row of the directed stimulus table
    typedef struct {
        kind_t       kind;
        logic [5:0]  row;
        logic [5:0]  col;
        code_t       code;
        logic [11:0] step;
        bit          typed;     // expected value given in the row itself
        status_t     status;
        logic [12:0] length;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [6:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    // predictor state
    code_t       maze_cells [GridCells];
    bit          trail_marks [GridCells];
    int          trail_cells [GridCells];
    int          trail_dirs [GridCells];
    int          route_len;
    status_t     route_state;
    int          rows_reg;
    int          cols_reg;

    path_result_t expected_results[$];
    int          error_count;
    int          cycle_count;

    grid_maze_dfs_path_finder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // no idling on either side in this window of the run
    function automatic bit calm_window();
        return cycle_count >= 4000 && cycle_count < 9000;
    endfunction

    // register value 0 acts as 1, anything above the store size as the maximum
    function automatic int clamp_dim(int v);
        if (v == 0)
        begin
            return 1;
        end
        return (v > 64) ? 64 : v;
    endfunction

    // depth-first search from the start cell, neighbors up, down, left, right
    function automatic void search_path();
        int rows;
        int cols;
        int starts;
        int exits;
        int origin;
        int depth;
        int top;
        int p;
        int d;
        int nr;
        int nc;
        int np;
        bit found;
        rows = clamp_dim(rows_reg);
        cols = clamp_dim(cols_reg);
        starts = 0;
        exits = 0;
        origin = 0;
        found = 1'b0;
        route_len = 0;
        for (int r = 0; r < rows; r++)
        begin
            for (int c = 0; c < cols; c++)
            begin
                if (maze_cells[r * GridCols + c] == CODE_START)
                begin
                    starts++;
                    origin = r * GridCols + c;
                end
                else if (maze_cells[r * GridCols + c] == CODE_EXIT)
                begin
                    exits++;
                end
            end
        end
        if (starts != 1 || exits != 1)
        begin
            route_state = ST_BADCNT;
            return;
        end
        foreach (trail_marks[i])
        begin
            trail_marks[i] = 1'b0;
        end
        trail_marks[origin] = 1'b1;
        trail_cells[0] = origin;
        trail_dirs[0] = 0;
        depth = 1;
        while (depth > 0 && !found)
        begin
            top = depth - 1;
            p = trail_cells[top];
            d = trail_dirs[top];
            if (d >= 4)
            begin
                // every direction tried, back out of this cell
                trail_marks[p] = 1'b0;
                depth--;
            end
            else
            begin
                trail_dirs[top] = d + 1;
                nr = p / GridCols + ((d == 0) ? -1 : (d == 1) ? 1 : 0);
                nc = p % GridCols + ((d == 2) ? -1 : (d == 3) ? 1 : 0);
                if (nr >= 0 && nc >= 0 && nr < rows && nc < cols)
                begin
                    np = nr * GridCols + nc;
                    if (maze_cells[np] != CODE_WALL && !trail_marks[np] && depth < GridCells)
                    begin
                        trail_cells[depth] = np;
                        if (maze_cells[np] == CODE_EXIT)
                        begin
                            route_len = depth + 1;
                            found = 1'b1;
                        end
                        else
                        begin
                            trail_marks[np] = 1'b1;
                            trail_dirs[depth] = 0;
                            depth++;
                        end
                    end
                end
            end
        end
        route_state = found ? ST_OK : ST_NOPATH;
    endfunction

    // expected result item for one input item, updates the predictor state
    function automatic path_result_t predict_result(kind_t kind, logic [5:0] row,
                                                    logic [5:0] col, code_t code,
                                                    logic [11:0] step);
        path_result_t res;
        int p;
        res = '{ST_OK, 13'd0, 6'd0, 6'd0};
        case (kind)
            KIND_WRITE:
            begin
                maze_cells[row * GridCols + col] = code;
            end
            KIND_SOLVE:
            begin
                search_path();
                res.status = route_state;
                res.length = 13'(route_len);
            end
            KIND_READ:
            begin
                if (route_state != ST_OK)
                begin
                    res.status = route_state;
                end
                else if (step >= route_len)
                begin
                    res.status = ST_RANGE;
                    res.length = 13'(route_len);
                end
                else
                begin
                    p = trail_cells[step];
                    res.length = 13'(route_len);
                    res.row = 6'(p / GridCols);
                    res.col = 6'(p % GridCols);
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // hand one item to the block, with random idle cycles in front of it
    task automatic send_item(kind_t kind, logic [5:0] row, logic [5:0] col, code_t code,
                             logic [11:0] step, bit typed, path_result_t typed_res);
        path_result_t res;
        path_result_t want;
        res = predict_result(kind, row, col, code, step);
        while (!calm_window() && $urandom_range(0, 99) < IdlePct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        want = typed ? typed_res : res;
        expected_results = {expected_results, want};
        s_tvalid <= 1'b1;
        // kind, cell_row, cell_col, cell_code, step_index from bit 0 up
        s_tdata <= {4'd0, step, code, col, row, kind};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
    endtask

    task automatic send_random(kind_t kind, logic [5:0] row, logic [5:0] col, code_t code,
                               logic [11:0] step);
        send_item(kind, row, col, code, step, 1'b0, '{ST_OK, 13'd0, 6'd0, 6'd0});
    endtask

    // wait until every result is back, then write both size registers
    task automatic set_size(int rows_val, int cols_val);
        s_tvalid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (12) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_ROWS;
        cfg_data <= rows_val[6:0];
        @(posedge clk);
        cfg_index <= REG_COLS;
        cfg_data <= cols_val[6:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        rows_reg = rows_val;
        cols_reg = cols_val;
    endtask

    // one phase: new size, fresh random maze over the whole active area, random traffic
    task automatic run_phase(int rows_val, int cols_val, int n_items);
        int rows;
        int cols;
        int layout;
        int pick;
        logic [11:0] step;
        set_size(rows_val, cols_val);
        rows = clamp_dim(rows_val);
        cols = clamp_dim(cols_val);
        for (int r = 0; r < rows; r++)
        begin
            for (int c = 0; c < cols; c++)
            begin
                send_random(KIND_WRITE, 6'(r), 6'(c),
                            ($urandom_range(0, 99) < 30) ? CODE_WALL : CODE_OPEN, 12'd0);
            end
        end
        // mostly one start and one exit, sometimes a missing or doubled marker
        layout = $urandom_range(0, 9);
        if (layout != 0)
        begin
            send_random(KIND_WRITE, 6'($urandom_range(0, rows - 1)),
                        6'($urandom_range(0, cols - 1)), CODE_START, 12'd0);
        end
        send_random(KIND_WRITE, 6'($urandom_range(0, rows - 1)),
                    6'($urandom_range(0, cols - 1)), CODE_EXIT, 12'd0);
        if (layout == 1)
        begin
            send_random(KIND_WRITE, 6'($urandom_range(0, rows - 1)),
                        6'($urandom_range(0, cols - 1)), code_t'($urandom_range(2, 3)),
                        12'd0);
        end
        send_random(KIND_SOLVE, 6'd0, 6'd0, CODE_OPEN, 12'd0);
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 99);
            step = ($urandom_range(0, 9) < 8) ? 12'($urandom_range(0, route_len + 1))
                                              : 12'($urandom_range(0, 4095));
            if (pick < 8 && rows * cols < 1024)
            begin
                send_random(KIND_SOLVE, 6'($urandom), 6'($urandom),
                            code_t'($urandom_range(0, 3)), step);
            end
            else if (pick < 60)
            begin
                send_random(KIND_READ, 6'($urandom), 6'($urandom),
                            code_t'($urandom_range(0, 3)), step);
            end
            else if (pick < 80)
            begin
                // keep most rewrites to open or wall so the maze stays solvable
                send_random(KIND_WRITE, 6'($urandom_range(0, rows - 1)),
                            6'($urandom_range(0, cols - 1)),
                            ($urandom_range(0, 9) < 8) ? code_t'($urandom_range(0, 1))
                                                       : code_t'($urandom_range(0, 3)), step);
            end
            else if (pick < 92)
            begin
                send_random(KIND_WRITE, 6'($urandom), 6'($urandom),
                            code_t'($urandom_range(0, 3)), step);
            end
            else
            begin
                send_random(KIND_NONE, 6'($urandom), 6'($urandom),
                            code_t'($urandom_range(0, 3)), step);
            end
        end
    endtask

    // result side: random stalls, compare against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result item %h", $time, m_tdata);
                    error_count++;
                end
                else
                begin
                    // status, path_length, path_row, path_col from bit 0 up
                    if (m_tdata[1:0] !== expected_results[0].status ||
                        m_tdata[14:2] !== expected_results[0].length ||
                        m_tdata[20:15] !== expected_results[0].row ||
                        m_tdata[26:21] !== expected_results[0].col ||
                        m_tdata[31:27] !== 5'd0)
                    begin
                        $display("%0t: expected status %0d len %0d row %0d col %0d, got %0d %0d %0d %0d",
                                 $time, expected_results[0].status, expected_results[0].length,
                                 expected_results[0].row, expected_results[0].col,
                                 m_tdata[1:0], m_tdata[14:2], m_tdata[20:15], m_tdata[26:21]);
                        error_count++;
                    end
                    void'(expected_results.pop_front());
                end
            end
            m_tready <= calm_window() || ($urandom_range(0, 99) >= IdlePct);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        plan_row_t plan[19];
        // 2x2 maze: start top left, wall bottom left, exit bottom right
        plan = '{
            '{KIND_READ,  6'd0,  6'd0,  CODE_OPEN,  12'd0,    1'b1, ST_NOPATH, 13'd0},
            '{KIND_NONE,  6'd63, 6'd63, CODE_EXIT,  12'd4095, 1'b1, ST_OK,     13'd0},
            '{KIND_WRITE, 6'd0,  6'd0,  CODE_START, 12'd0,    1'b1, ST_OK,     13'd0},
            '{KIND_WRITE, 6'd0,  6'd1,  CODE_OPEN,  12'd0,    1'b1, ST_OK,     13'd0},
            '{KIND_WRITE, 6'd1,  6'd0,  CODE_WALL,  12'd0,    1'b1, ST_OK,     13'd0},
            '{KIND_WRITE, 6'd1,  6'd1,  CODE_EXIT,  12'd0,    1'b1, ST_OK,     13'd0},
            '{KIND_SOLVE, 6'd0,  6'd0,  CODE_OPEN,  12'd0,    1'b0, ST_OK,     13'd0},
            '{KIND_READ,  6'd0,  6'd0,  CODE_OPEN,  12'd0,    1'b0, ST_OK,     13'd0},
            '{KIND_READ,  6'd0,  6'd0,  CODE_OPEN,  12'd2,    1'b0, ST_OK,     13'd0},
            '{KIND_READ,  6'd0,  6'd0,  CODE_OPEN,  12'd3,    1'b1, ST_RANGE,  13'd3},
            '{KIND_READ,  6'd0,  6'd0,  CODE_OPEN,  12'd4095, 1'b1, ST_RANGE,  13'd3},
            // outside the active area, ignored by the start and exit count
            '{KIND_WRITE, 6'd63, 6'd63, CODE_EXIT,  12'd0,    1'b1, ST_OK,     13'd0},
            '{KIND_WRITE, 6'd1,  6'd1,  CODE_OPEN,  12'd0,    1'b1, ST_OK,     13'd0},
            '{KIND_SOLVE, 6'd0,  6'd0,  CODE_OPEN,  12'd0,    1'b1, ST_BADCNT, 13'd0},
            '{KIND_READ,  6'd0,  6'd0,  CODE_OPEN,  12'd0,    1'b1, ST_BADCNT, 13'd0},
            '{KIND_WRITE, 6'd1,  6'd1,  CODE_EXIT,  12'd0,    1'b1, ST_OK,     13'd0},
            '{KIND_WRITE, 6'd0,  6'd1,  CODE_WALL,  12'd0,    1'b1, ST_OK,     13'd0},
            '{KIND_SOLVE, 6'd0,  6'd0,  CODE_OPEN,  12'd0,    1'b1, ST_NOPATH, 13'd0},
            '{KIND_READ,  6'd0,  6'd0,  CODE_OPEN,  12'd1,    1'b1, ST_NOPATH, 13'd0}
        };
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ROWS;
        cfg_data = 7'd0;
        s_tvalid = 1'b0;
        s_tdata = 32'd0;
        error_count = 0;
        cycle_count = 0;
        foreach (maze_cells[i])
        begin
            maze_cells[i] = CODE_OPEN;
            trail_cells[i] = 0;
        end
        route_len = 0;
        route_state = ST_NOPATH;
        rows_reg = 64;
        cols_reg = 64;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_size(2, 2);
        foreach (plan[i])
        begin
            send_item(plan[i].kind, plan[i].row, plan[i].col, plan[i].code, plan[i].step,
                      plan[i].typed, '{plan[i].status, plan[i].length, 6'd0, 6'd0});
        end

        // register extremes: 0 acts as 1, 127 as the full store
        run_phase(0, 5, 40);
        run_phase(1, 1, 30);
        run_phase(4, 5, 80);
        run_phase(1, 127, 50);
        run_phase(4, 4, 80);
        run_phase(127, 1, 30);
        run_phase(2, 8, 80);
        run_phase(64, 1, 50);
        run_phase(3, 6, 80);
        run_phase(5, 3, 50);

        s_tvalid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (20) @(posedge clk);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
